@@ rtl/mppt_pkg.sv @@
// ----------------------------------------------------------------------------
// mppt_pkg
// shared types and constants for the perturb-and-observe tracker
// ----------------------------------------------------------------------------
package mppt_pkg;

  // field widths
  localparam int unsigned SampleW = 16;   // q8.8 volts and amps
  localparam int unsigned PowerW  = 32;   // q16.16 watts
  localparam int unsigned DutyW   = 16;   // q1.15 duty
  localparam int unsigned CfgW    = 32;   // widest register
  localparam int unsigned CfgIdxW = 3;

  // duty constants, q1.15
  localparam logic [DutyW-1:0] DutyOne  = 16'd32768;
  localparam logic [DutyW-1:0] DutyHalf = 16'd16384;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_SIZE        = 3'd0,
    REG_MIN_DUTY         = 3'd1,
    REG_MAX_DUTY         = 3'd2,
    REG_POWER_DEADBAND   = 3'd3,
    REG_VOLTAGE_DEADBAND = 3'd4,
    REG_TIMER_TOP        = 3'd5
  } cfg_idx_e;

  // request to the shared multiplier
  typedef struct packed {
    logic               en;
    logic [SampleW-1:0] a;
    logic [SampleW-1:0] b;
  } mul_req_t;

endpackage

@@ rtl/mppt_mul.sv @@
// ----------------------------------------------------------------------------
// mppt_mul
// shared 16 x 16 unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module mppt_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mppt_pkg::mul_req_t       req_i,
  output logic [mppt_pkg::PowerW-1:0] prod_o
);
  import mppt_pkg::*;

  logic [PowerW-1:0] prod_q;

  // product register, loaded on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (req_i.en) begin
      prod_q <= PowerW'(req_i.a) * PowerW'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/mppt_perturb_observe.sv @@
// ----------------------------------------------------------------------------
// mppt_perturb_observe
// perturb-and-observe maximum power point tracker, fixed point
// ----------------------------------------------------------------------------
// One sample request (voltage and current, q8.8) yields one result request
// (duty q1.15 and timer compare value). A sample is taken only while the
// sequencer is idle; it then steps from acceptance to a loaded result
// through power product, deadband and direction decision, step and clamp,
// compare scaling and output load, so no new sample is taken before the
// last one is loaded. The steps are laid out around the single 16 x 16
// multiplier, which is used once for the power and once for the compare
// scaling. A loaded result waits in the output register; the next sample
// is accepted meanwhile, and the sequencer holds in its last step only if
// the previous result is still untaken. Registers are to be written through
// cfg_we_i only while no sample is in work; the block does not enforce it.
// ----------------------------------------------------------------------------
module mppt_perturb_observe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [mppt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mppt_pkg::CfgW-1:0]     cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,   // voltage[15:0], current[31:16]
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o    // duty[15:0], compare_value[31:16]
);
  import mppt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_POWER  = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_CLAMP  = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [DutyW-1:0]   step_size_q, min_duty_q, max_duty_q, timer_top_q;
  logic [PowerW-1:0]  power_deadband_q;
  logic [SampleW-1:0] voltage_deadband_q;

  // tracker state
  logic [SampleW-1:0] last_voltage_q;
  logic [PowerW-1:0]  last_power_q;
  logic [DutyW-1:0]   last_duty_q;

  // working registers
  logic [SampleW-1:0] volt_q, curr_q;
  logic [DutyW-1:0]   duty_q;
  logic               act_q, step_up_q;

  // output register
  logic               out_valid_q;
  logic [DutyW-1:0]   out_duty_q;
  logic [DutyW-1:0]   out_cmp_q;

  logic               in_acc;
  logic               out_free;
  mul_req_t           mul_req;
  logic [PowerW-1:0]  prod;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q        <= 16'd328;
      min_duty_q         <= 16'd0;
      max_duty_q         <= DutyOne;
      power_deadband_q   <= 32'd32768;
      voltage_deadband_q <= 16'd51;
      timer_top_q        <= 16'd456;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_STEP_SIZE:        step_size_q        <= cfg_data_i[DutyW-1:0];
        REG_MIN_DUTY:         min_duty_q         <= cfg_data_i[DutyW-1:0];
        REG_MAX_DUTY:         max_duty_q         <= cfg_data_i[DutyW-1:0];
        REG_POWER_DEADBAND:   power_deadband_q   <= cfg_data_i[PowerW-1:0];
        REG_VOLTAGE_DEADBAND: voltage_deadband_q <= cfg_data_i[SampleW-1:0];
        REG_TIMER_TOP:        timer_top_q        <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier: power first, then compare scaling
  always_comb begin
    mul_req = '0;
    if (state_q == ST_POWER) begin
      mul_req.en = 1'b1;
      mul_req.a  = volt_q;
      mul_req.b  = curr_q;
    end else if (state_q == ST_SCALE) begin
      mul_req.en = 1'b1;
      mul_req.a  = duty_q;
      mul_req.b  = timer_top_q;
    end
  end

  mppt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // deadband test and direction
  logic signed [SampleW:0] dv;
  logic signed [PowerW:0]  dp;
  logic [SampleW:0]        adv;
  logic [PowerW:0]         adp;
  logic                    act, step_up;

  always_comb begin
    dv      = $signed({1'b0, volt_q}) - $signed({1'b0, last_voltage_q});
    dp      = $signed({1'b0, prod}) - $signed({1'b0, last_power_q});
    adv     = dv[SampleW] ? (SampleW+1)'(-dv) : dv;
    adp     = dp[PowerW] ? (PowerW+1)'(-dp) : dp;
    act     = (adp > {1'b0, power_deadband_q}) && (adv > {1'b0, voltage_deadband_q});
    // same direction of power and voltage steps down
    step_up = ((dp > 0) != (dv > 0));
  end

  // step then clamp, max first and min last
  logic signed [DutyW+1:0] d_step;
  logic signed [DutyW+1:0] d_max;
  logic [DutyW-1:0]        duty_next;

  always_comb begin
    d_step = $signed({2'b00, last_duty_q});
    if (act_q) begin
      if (step_up_q) begin
        d_step = d_step + $signed({2'b00, step_size_q});
      end else begin
        d_step = d_step - $signed({2'b00, step_size_q});
      end
    end
    d_max = (d_step > $signed({2'b00, max_duty_q})) ? $signed({2'b00, max_duty_q}) : d_step;
    if (d_max < $signed({2'b00, min_duty_q})) begin
      duty_next = min_duty_q;
    end else begin
      duty_next = d_max[DutyW-1:0];
    end
  end

  // compare value with round-half-up
  logic [PowerW-1:0] rounded;
  logic [DutyW-1:0]  cmp_next;

  always_comb begin
    rounded = prod + PowerW'(DutyHalf);
    priority if (duty_q >= DutyOne) begin
      cmp_next = timer_top_q;
    end else if (duty_q == '0) begin
      cmp_next = '0;
    end else begin
      cmp_next = rounded[DutyW+14:15];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_POWER;
      ST_POWER:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // tracker state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_voltage_q <= '0;
      last_power_q   <= '0;
      last_duty_q    <= DutyHalf;
    end else begin
      if (state_q == ST_DECIDE) begin
        last_voltage_q <= volt_q;
        last_power_q   <= prod;
      end
      if (state_q == ST_CLAMP) begin
        last_duty_q <= duty_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      volt_q <= s_axis_tdata_i[SampleW-1:0];
      curr_q <= s_axis_tdata_i[2*SampleW-1:SampleW];
    end
    if (state_q == ST_DECIDE) begin
      act_q     <= act;
      step_up_q <= step_up;
    end
    if (state_q == ST_CLAMP) begin
      duty_q <= duty_next;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_duty_q <= duty_q;
      out_cmp_q  <= cmp_next;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cmp_q, out_duty_q};

  // accepted sample starts the power product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_POWER) && !s_axis_tready_o)
    else $error("sample accepted but sequencer did not start");

  // a finished result holds while the output slot is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !out_free |=> (state_q == ST_EMIT))
    else $error("result dropped while output stalled");

  // delivered duty respects the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= max_duty_q) || (out_duty_q == min_duty_q))
    else $error("duty outside clamp range");

  // compare value never exceeds timer top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cmp_q <= timer_top_q))
    else $error("compare value above timer top");

endmodule
